// ===== src/cfwd_pkg.sv =====
`default_nettype none
package cfwd_pkg;

    localparam int DEPTH  = 8;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_DUMP = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_OVERFLOW   = 2'd1,
        STATUS_UNDERFLOW  = 2'd2,
        STATUS_DUMP_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] push_data;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] read_data;
        logic                     last_of_run;
        logic                     is_full;
        logic                     is_empty;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_DUMP
    } t_state;

    typedef struct packed {
        logic do_push;
        logic pop_rd;
        logic pop_err;
        logic pop_emit;
        logic dump_rd_head;
        logic dump_rd_next;
        logic dump_emit;
        logic dump_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic rd_last;
    } t_dp_stat;

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] res;
        if (idx == ADDR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + ADDR_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/cfwd_ctrl.sv =====
`default_nettype none
module cfwd_ctrl
    import cfwd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_func,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd,
    output logic            o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_func)
                        FUNC_PUSH: begin
                            o_cmd.do_push = 1'b1;
                        end
                        FUNC_POP: begin
                            if (i_stat.empty) begin
                                o_cmd.pop_err = 1'b1;
                            end else begin
                                o_cmd.pop_rd = 1'b1;
                                n_state      = ST_POP;
                            end
                        end
                        FUNC_DUMP: begin
                            if (i_stat.empty) begin
                                o_cmd.dump_empty = 1'b1;
                            end else begin
                                o_cmd.dump_rd_head = 1'b1;
                                n_state            = ST_DUMP;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP: begin
                o_cmd.pop_emit = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_DUMP: begin
                o_cmd.dump_emit = 1'b1;
                if (i_stat.rd_last) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.dump_rd_next = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/cfwd_datapath.sv =====
`default_nettype none
module cfwd_datapath
    import cfwd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    input  wire logic signed [DATA_W-1:0] i_push_data,
    output t_dp_stat                      o_stat,
    output t_out_item                     o_result,
    output logic                          o_strobe
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    logic [ADDR_W-1:0] r_head;
    logic [ADDR_W-1:0] r_tail;
    logic              r_empty;
    logic [ADDR_W-1:0] r_ptr;
    logic              r_rd_last;
    t_out_item         r_out;
    logic              r_strobe;

    logic [ADDR_W-1:0] n_head;
    logic [ADDR_W-1:0] n_tail;
    logic              n_empty;
    logic [ADDR_W-1:0] n_ptr;
    logic              n_rd_last;
    t_out_item         n_out;
    logic              n_strobe;

    logic              full;
    logic              n_full;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign full   = !r_empty && (next_slot(r_tail) == r_head);
    assign n_full = !n_empty && (next_slot(n_tail) == n_head);
    assign wr_en  = i_cmd.do_push && !full;
    assign rd_en  = i_cmd.pop_rd || i_cmd.dump_rd_head || i_cmd.dump_rd_next;
    assign rd_addr = i_cmd.dump_rd_next ? r_ptr : r_head;

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        n_ptr     = r_ptr;
        n_rd_last = r_rd_last;
        if (wr_en) begin
            if (r_empty) begin
                n_head  = '0;
                n_tail  = '0;
                n_empty = 1'b0;
            end else begin
                n_tail = next_slot(r_tail);
            end
        end
        if (i_cmd.pop_rd) begin
            if (r_head == r_tail) begin
                n_head  = '0;
                n_tail  = '0;
                n_empty = 1'b1;
            end else begin
                n_head = next_slot(r_head);
            end
        end
        if (i_cmd.dump_rd_head || i_cmd.dump_rd_next) begin
            n_ptr     = next_slot(rd_addr);
            n_rd_last = (rd_addr == r_tail);
        end
    end

    always_comb begin
        n_out             = r_out;
        n_strobe          = 1'b0;
        n_out.is_full     = n_full;
        n_out.is_empty    = n_empty;
        n_out.last_of_run = 1'b1;
        n_out.read_data   = '0;
        n_out.status      = STATUS_OK;
        if (i_cmd.do_push) begin
            n_strobe     = 1'b1;
            n_out.status = full ? STATUS_OVERFLOW : STATUS_OK;
        end
        if (i_cmd.pop_err) begin
            n_strobe     = 1'b1;
            n_out.status = STATUS_UNDERFLOW;
        end
        if (i_cmd.dump_empty) begin
            n_strobe     = 1'b1;
            n_out.status = STATUS_DUMP_EMPTY;
        end
        if (i_cmd.pop_emit) begin
            n_strobe        = 1'b1;
            n_out.read_data = r_rdata;
        end
        if (i_cmd.dump_emit) begin
            n_strobe          = 1'b1;
            n_out.read_data   = r_rdata;
            n_out.last_of_run = r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[n_tail] <= i_push_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_empty   <= 1'b1;
            r_ptr     <= '0;
            r_rd_last <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_empty   <= n_empty;
            r_ptr     <= n_ptr;
            r_rd_last <= n_rd_last;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_stat.empty   = r_empty;
    assign o_stat.rd_last = r_rd_last;
    assign o_result       = r_out;
    assign o_strobe       = r_strobe;

endmodule
`default_nettype wire

// ===== src/circular_fifo_with_dump.sv =====
// Ring-buffer queue of signed 32-bit words, DEPTH entries deep.
// A transaction is accepted on a rising edge where start is high and busy is low.
// The command field selects push, pop or dump; code 3 is accepted and ignored.
// Every result appears on o_result for one cycle with o_strobe high, and it
// carries the full and empty flags as they stand after the operation.
// A push, or any error result, is returned in the cycle after acceptance and
// busy stays low, so a push can be accepted every cycle.
// A pop of a stored word reads the entry memory, whose read port is
// registered, so its result passes through the read-data and output registers,
// and busy is high while the result is formed.
// A dump of N stored entries emits N results on consecutive cycles, oldest first,
// with last_of_run on the final one, each through the read-data and output
// registers; busy is high during the run, paced by the single memory read port.
// Synchronous reset empties the queue and returns the controller to idle;
// the entry memory is not cleared.
// The receiver cannot stall, so every result must be taken when strobed.
`default_nettype none
module circular_fifo_with_dump
    import cfwd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_in_item  i_item,
    output logic           busy,
    output t_out_item      o_result,
    output logic           o_strobe
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cfwd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_item.func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    cfwd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_push_data (i_item.push_data),
        .o_stat      (stat),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

endmodule
`default_nettype wire
